/* design/snpdec_pkg.sv */
package snpdec_pkg;

  localparam int WINDOW_DEPTH_DEF = 65536;
  localparam int MAX_RESULTS = 64;

  // Result status codes
  localparam logic [1:0] ST_DATA    = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_CORRUPT = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       byte_present;
    logic       end_of_stream;
  } item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  status;
    logic [31:0] decoded_length;
    logic        run_last;
  } result_t;

  // Stream decode phase
  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_TAG     = 3'd1,
    PH_EXTRA   = 3'd2,
    PH_LITERAL = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;
    logic held;
    logic take;
    logic copy_rd;
    logic copy_wr;
    logic eos;
    logic flush;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic can_push;
    logic held_valid;
    logic copy_start;
    logic copy_last;
  } stat_t;

endpackage

/* design/snpdec_ctrl.sv */
module snpdec_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  snpdec_pkg::stat_t   stat,
  output snpdec_pkg::cmd_t    cmd
);
  import snpdec_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_HELD  = 7'b0000010,
    S_TAKE  = 7'b0000100,
    S_CRD   = 7'b0001000,
    S_CWR   = 7'b0010000,
    S_EOS   = 7'b0100000,
    S_FLUSH = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign item_stall = (state != S_IDLE);

  // Sequence one item: held result, byte, copy loop, end marker, flush
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.latch = 1'b1;
          state_next = S_HELD;
        end
      end
      S_HELD: begin
        if (!stat.held_valid) begin
          state_next = S_TAKE;
        end else if (stat.can_push) begin
          cmd.held = 1'b1;
          state_next = S_TAKE;
        end
      end
      S_TAKE: begin
        if (stat.can_push) begin
          cmd.take = 1'b1;
          state_next = stat.copy_start ? S_CRD : S_EOS;
        end
      end
      S_CRD: begin
        cmd.copy_rd = 1'b1;
        state_next = S_CWR;
      end
      S_CWR: begin
        if (stat.can_push) begin
          cmd.copy_wr = 1'b1;
          state_next = stat.copy_last ? S_EOS : S_CRD;
        end
      end
      S_EOS: begin
        if (stat.can_push) begin
          cmd.eos = 1'b1;
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (stat.can_push) begin
          cmd.flush = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* design/snpdec_dp.sv */
module snpdec_dp #(
  parameter int WINDOW_DEPTH = snpdec_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [31:0]          cfg_data,
  input  snpdec_pkg::item_t    item,
  input  snpdec_pkg::cmd_t     cmd,
  output snpdec_pkg::stat_t    stat,
  output logic                 result_valid,
  input  logic                 result_stall,
  output snpdec_pkg::result_t  result
);
  import snpdec_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);

  logic [31:0] max_len;
  item_t       it;

  phase_t      phase, phase_next;
  logic [31:0] vv, vv_next;
  logic [2:0]  vc, vc_next;
  logic [31:0] exp_len, exp_len_next;
  logic [31:0] prod, prod_next;
  logic [7:0]  tag, tag_next;
  logic [31:0] ev, ev_next;
  logic [2:0]  er, er_next;
  logic [32:0] lit, lit_next;
  logic        failed, failed_next;
  logic [AW-1:0] wptr, wptr_next;
  logic [AW:0]   coff, coff_next;
  logic [6:0]    clen, clen_next;
  logic          held_v, held_v_next;
  logic [1:0]    held_st, held_st_next;
  logic [31:0]   held_len, held_len_next;
  logic [6:0]    res_cnt;

  logic          push;
  result_t       push_res;
  logic          we, re;
  logic [7:0]    wdata, rdata;
  logic [AW-1:0] raddr;
  logic [AW:0]   wext, rfull;

  logic [7:0]  mem [WINDOW_DEPTH];

  logic          pend_v, out_v;
  result_t       pend_r, out_r;

  logic        active;
  logic [7:0]  b;
  logic [2:0]  need, k;
  logic [31:0] ev_new, hdr_bits, c_off;
  logic [6:0]  c_len;
  logic        copy_ok;
  logic [32:0] room;

  assign b      = it.in_byte;
  assign active = it.byte_present && !failed;
  assign room   = {1'b0, exp_len} - {1'b0, prod};

  // Extra bytes a tag needs
  always_comb begin
    case (tag[1:0])
      2'd0:    need = 3'(tag[7:2] - 6'd59);
      2'd1:    need = 3'd1;
      2'd2:    need = 3'd2;
      default: need = 3'd4;
    endcase
  end

  assign k      = need - er;
  assign ev_new = ev | (32'(b) << {k[1:0], 3'b000});
  assign c_off  = (tag[1:0] == 2'd1) ? {21'd0, tag[7:5], ev_new[7:0]} : ev_new;
  assign c_len  = (tag[1:0] == 2'd1) ? 7'(tag[4:2]) + 7'd4 : 7'(tag[7:2]) + 7'd1;
  assign copy_ok = (c_off != 32'd0) && (c_off <= prod) &&
                   ({1'b0, c_off} <= 33'(WINDOW_DEPTH)) &&
                   (({1'b0, prod} + 33'(c_len)) <= {1'b0, exp_len});

  // Varint payload bits placed by byte count
  always_comb begin
    case (vc[1:0])
      2'd0:    hdr_bits = {25'd0, b[6:0]};
      2'd1:    hdr_bits = {18'd0, b[6:0], 7'd0};
      2'd2:    hdr_bits = {11'd0, b[6:0], 14'd0};
      default: hdr_bits = {4'd0, b[6:0], 21'd0};
    endcase
  end

  // Window read address behind the write pointer
  assign wext  = {1'b0, wptr};
  assign rfull = (wext >= coff) ? wext - coff
                                : wext + (AW+1)'(WINDOW_DEPTH) - coff;
  assign raddr = rfull[AW-1:0];

  assign stat.can_push   = !pend_v || !out_v || !result_stall;
  assign stat.held_valid = held_v;
  assign stat.copy_last  = (clen == 7'd1);
  assign stat.copy_start = active && (phase == PH_EXTRA) && (er == 3'd1) &&
                           (tag[1:0] != 2'd0) && copy_ok;

  // Stream decode step
  always_comb begin
    phase_next = phase;   vv_next = vv;       vc_next = vc;
    exp_len_next = exp_len; prod_next = prod; tag_next = tag;
    ev_next = ev;         er_next = er;       lit_next = lit;
    failed_next = failed; wptr_next = wptr;   coff_next = coff;
    clen_next = clen;     held_v_next = held_v;
    held_st_next = held_st; held_len_next = held_len;
    push = 1'b0;
    push_res = '0;
    we = 1'b0;
    wdata = b;
    re = cmd.copy_rd;

    if (cmd.held) begin
      push = 1'b1;
      push_res.status = held_st;
      push_res.decoded_length = held_len;
      held_v_next = 1'b0;
    end

    if (cmd.take && active) begin
      unique case (phase)
        PH_HEADER: begin
          if (vc < 3'd4 || b < 8'd16) begin
            vc_next = vc + 3'd1;
            vv_next = (vc < 3'd4) ? (vv | hdr_bits) : (vv | {b[3:0], 28'd0});
            if (vc == 3'd4 || b < 8'd128) begin
              if (vv_next > max_len) begin
                failed_next = 1'b1;
                push = 1'b1;
                push_res.status = ST_CORRUPT;
              end else begin
                exp_len_next = vv_next;
                prod_next = '0;
                wptr_next = '0;
                phase_next = (vv_next == 32'd0) ? PH_DONE : PH_TAG;
              end
            end
          end else begin
            failed_next = 1'b1;
            push = 1'b1;
            push_res.status = ST_CORRUPT;
          end
        end
        PH_TAG: begin
          tag_next = b;
          if (b[1:0] == 2'd0 && b[7:2] < 6'd60) begin
            if ((33'(b[7:2]) + 33'd1) > room) begin
              failed_next = 1'b1;
              push = 1'b1;
              push_res.status = ST_CORRUPT;
            end else begin
              lit_next = 33'(b[7:2]) + 33'd1;
              phase_next = PH_LITERAL;
            end
          end else begin
            ev_next = '0;
            case (b[1:0])
              2'd0:    er_next = 3'(b[7:2] - 6'd59);
              2'd1:    er_next = 3'd1;
              2'd2:    er_next = 3'd2;
              default: er_next = 3'd4;
            endcase
            phase_next = PH_EXTRA;
          end
        end
        PH_EXTRA: begin
          ev_next = ev_new;
          er_next = er - 3'd1;
          if (er == 3'd1) begin
            if (tag[1:0] == 2'd0) begin
              if (({1'b0, ev_new} + 33'd1) > room) begin
                failed_next = 1'b1;
                push = 1'b1;
                push_res.status = ST_CORRUPT;
              end else begin
                lit_next = {1'b0, ev_new} + 33'd1;
                phase_next = PH_LITERAL;
              end
            end else if (copy_ok) begin
              coff_next = c_off[AW:0];
              clen_next = c_len;
            end else begin
              failed_next = 1'b1;
              push = 1'b1;
              push_res.status = ST_CORRUPT;
            end
          end
        end
        PH_LITERAL: begin
          we = 1'b1;
          wptr_next = (wptr == AW'(WINDOW_DEPTH - 1)) ? '0 : wptr + 1'b1;
          prod_next = prod + 32'd1;
          push = 1'b1;
          push_res.out_byte = b;
          lit_next = lit - 33'd1;
          if (lit == 33'd1) begin
            phase_next = (prod_next == exp_len) ? PH_DONE : PH_TAG;
          end
        end
        default: begin
          failed_next = 1'b1;
          push = 1'b1;
          push_res.status = ST_CORRUPT;
        end
      endcase
    end

    // Emit one copied byte
    if (cmd.copy_wr) begin
      we = 1'b1;
      wdata = rdata;
      wptr_next = (wptr == AW'(WINDOW_DEPTH - 1)) ? '0 : wptr + 1'b1;
      prod_next = prod + 32'd1;
      push = 1'b1;
      push_res.out_byte = rdata;
      clen_next = clen - 7'd1;
      if (clen == 7'd1) begin
        phase_next = (prod_next == exp_len) ? PH_DONE : PH_TAG;
      end
    end

    // Close the stream on an end marker
    if (cmd.eos && it.end_of_stream) begin
      if (!failed) begin
        if (phase == PH_DONE) begin
          push_res.status = ST_DONE;
          push_res.decoded_length = exp_len;
        end else if (phase == PH_HEADER && vc == 3'd0) begin
          push_res.status = ST_DONE;
        end else begin
          push_res.status = ST_CORRUPT;
        end
        if (res_cnt == 7'(MAX_RESULTS)) begin
          held_v_next = 1'b1;
          held_st_next = push_res.status;
          held_len_next = push_res.decoded_length;
        end else begin
          push = 1'b1;
        end
      end
      phase_next = PH_HEADER;
      vv_next = '0;  vc_next = '0;  exp_len_next = '0;  prod_next = '0;
      tag_next = '0; ev_next = '0;  er_next = '0;       lit_next = '0;
      failed_next = 1'b0;
    end
  end

  // History window
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wptr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // Decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= 32'hFFFF_FFFF;
      phase <= PH_HEADER;
      vv <= '0;  vc <= '0;  exp_len <= '0;  prod <= '0;
      tag <= '0; ev <= '0;  er <= '0;       lit <= '0;
      failed <= 1'b0;
      wptr <= '0;
      held_v <= 1'b0;
      res_cnt <= '0;
    end else begin
      if (cfg_valid) begin
        max_len <= cfg_data;
      end
      phase <= phase_next;   vv <= vv_next;     vc <= vc_next;
      exp_len <= exp_len_next; prod <= prod_next; tag <= tag_next;
      ev <= ev_next;         er <= er_next;     lit <= lit_next;
      failed <= failed_next; wptr <= wptr_next;
      held_v <= held_v_next;
      if (cmd.latch) begin
        res_cnt <= '0;
      end else if (push) begin
        res_cnt <= res_cnt + 7'd1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    coff <= coff_next;
    clen <= clen_next;
    held_st <= held_st_next;
    held_len <= held_len_next;
    if (cmd.latch) begin
      it <= item;
    end
  end

  // Hold one result back until its run_last is known
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
      out_v <= 1'b0;
    end else if (push) begin
      if (pend_v) begin
        out_r <= pend_r;
        out_v <= 1'b1;
      end else if (out_v && !result_stall) begin
        out_v <= 1'b0;
      end
      pend_r <= push_res;
      pend_v <= 1'b1;
    end else if (cmd.flush && pend_v) begin
      out_r <= '{out_byte: pend_r.out_byte, status: pend_r.status,
                 decoded_length: pend_r.decoded_length, run_last: 1'b1};
      out_v <= 1'b1;
      pend_v <= 1'b0;
    end else if (out_v && !result_stall) begin
      out_v <= 1'b0;
    end
  end

  assign result_valid = out_v;
  assign result = out_r;

endmodule

/* design/snappy_stream_decompressor.sv */
// Snappy stream decompressor taking one compressed byte per word and giving
// one result word per decoded byte, plus a status word at stream end (or at
// the first fault). Each input word passes through the controller steps
// (accept, held result, byte decode, end check, flush), and a copy tag
// adds a registered read of the history window before each write of a
// copied byte. Results leave through a one-entry hold stage plus an output
// register, so a result is shown once the next one (or the end of the word)
// is known. No clearing pass is run after reset; the window is only read at
// bytes written in the current stream.
module snappy_stream_decompressor #(
  parameter int WINDOW_DEPTH = snpdec_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  snpdec_pkg::item_t    item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output snpdec_pkg::result_t  result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [31:0]          cfg_data
);
  import snpdec_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  snpdec_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  snpdec_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

/* verif/snappy_stream_decompressor_tb.sv */
`timescale 1ns / 100ps

module snappy_stream_decompressor_tb;
  import snpdec_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;

  always #2 clk = ~clk;

  snappy_stream_decompressor uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  item_t pending_words[$];
  result_t expected_words[$];
  int errors = 0;

  // Decoder model state
  logic [31:0] max_len = 32'hFFFF_FFFF;
  phase_t ph = PH_HEADER;
  logic [31:0] vval = '0;
  int unsigned vcnt = 0;
  logic [31:0] exp_len = '0;
  logic [31:0] prod = '0;
  logic [7:0] ptag = '0;
  logic [31:0] xval = '0;
  int unsigned xrem = 0;
  longint unsigned lit_rem = 0;
  logic [7:0] hist [0:WINDOW_DEPTH_DEF-1];
  bit failed = 0;
  bit held_v = 0;
  logic [1:0] held_st = '0;
  logic [31:0] held_len = '0;
  result_t rb [0:67];
  int nres = 0;

  function automatic void dec_put(logic [7:0] b, logic [1:0] st, logic [31:0] l);
    if (nres < 68) begin
      rb[nres] = '{b, st, l, 1'b0};
      nres++;
    end
  endfunction

  function automatic void dec_fail();
    if (!failed) begin
      failed = 1;
      dec_put(8'd0, ST_CORRUPT, 32'd0);
    end
  endfunction

  function automatic void dec_emit(logic [7:0] b);
    hist[prod % WINDOW_DEPTH_DEF] = b;
    prod++;
    dec_put(b, ST_DATA, 32'd0);
  endfunction

  function automatic void dec_after();
    ph = (prod == exp_len) ? PH_DONE : PH_TAG;
  endfunction

  function automatic void dec_literal(longint unsigned n);
    longint unsigned room;
    room = longint'(exp_len) - longint'(prod);
    if (n > room) begin
      dec_fail();
      return;
    end
    lit_rem = n;
    ph = PH_LITERAL;
  endfunction

  function automatic void dec_copy(logic [31:0] off, int unsigned n);
    if (off == 0 || off > prod || longint'(off) > WINDOW_DEPTH_DEF) begin
      dec_fail();
      return;
    end
    if (longint'(prod) + n > longint'(exp_len)) begin
      dec_fail();
      return;
    end
    for (int i = 0; i < n; i++) dec_emit(hist[(prod - off) % WINDOW_DEPTH_DEF]);
    dec_after();
  endfunction

  function automatic int unsigned extra_len(logic [7:0] tag);
    case (tag[1:0])
      2'd0: return tag[7:2] - 59;
      2'd1: return 1;
      2'd2: return 2;
      default: return 4;
    endcase
  endfunction

  function automatic void dec_byte(logic [7:0] b);
    int unsigned k;
    case (ph)
      PH_HEADER: begin
        if (vcnt < 4) begin
          vval |= {25'd0, b[6:0]} << (7 * vcnt);
          vcnt++;
          if (b[7]) return;
        end else begin
          if (b >= 16) begin
            dec_fail();
            return;
          end
          vval |= {b[3:0], 28'd0};
          vcnt++;
        end
        // header complete
        if (vval > max_len) begin
          dec_fail();
          return;
        end
        exp_len = vval;
        prod = '0;
        ph = (exp_len == 0) ? PH_DONE : PH_TAG;
      end
      PH_TAG: begin
        ptag = b;
        if (b[1:0] == 2'd0 && b[7:2] < 60) begin
          dec_literal(b[7:2] + 1);
        end else begin
          xval = '0;
          xrem = extra_len(b);
          ph = PH_EXTRA;
        end
      end
      PH_EXTRA: begin
        k = extra_len(ptag) - xrem;
        xval |= {24'd0, b} << (8 * (k & 3));
        xrem--;
        if (xrem == 0) begin
          case (ptag[1:0])
            2'd0: dec_literal(longint'(xval) + 1);
            2'd1: dec_copy({21'd0, ptag[7:5], 8'd0} | xval, ptag[4:2] + 4);
            default: dec_copy(xval, ptag[7:2] + 1);
          endcase
        end
      end
      PH_LITERAL: begin
        dec_emit(b);
        lit_rem--;
        if (lit_rem == 0) dec_after();
      end
      default: dec_fail();
    endcase
  endfunction

  // Work out the results of one accepted word
  function automatic void decode_word(item_t it);
    int n;
    nres = 0;
    if (held_v) begin
      dec_put(8'd0, held_st, held_len);
      held_v = 0;
    end
    if (it.byte_present && !failed) dec_byte(it.in_byte);
    if (it.end_of_stream) begin
      if (!failed) begin
        if (ph == PH_DONE) dec_put(8'd0, ST_DONE, exp_len);
        else if (ph == PH_HEADER && vcnt == 0) dec_put(8'd0, ST_DONE, 32'd0);
        else dec_fail();
      end
      ph = PH_HEADER; vval = '0; vcnt = 0; exp_len = '0; prod = '0;
      ptag = '0; xval = '0; xrem = 0; lit_rem = 0; failed = 0;
    end
    n = nres;
    if (n > MAX_RESULTS) begin
      held_v = 1;
      held_st = rb[MAX_RESULTS].status;
      held_len = rb[MAX_RESULTS].decoded_length;
      n = MAX_RESULTS;
    end
    for (int i = 0; i < n; i++) begin
      rb[i].run_last = (i == n - 1);
      expected_words.push_back(rb[i]);
    end
  endfunction

  // Sender: bursts and gaps, hold the word while stalled
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    bit acc;
    bit nv;
    acc = item_valid && !item_stall;
    nv = item_valid;
    if (rst) begin
      nv = 1'b0;
    end else begin
      if (acc) decode_word(item);
      if (!item_valid || acc) begin
        nv = 1'b0;
        if (burst_left == 0 && gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() > 0) begin
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
          burst_left--;
          item <= pending_words.pop_front();
          nv = 1'b1;
        end
      end
    end
    item_valid <= nv;
  end

  // Receiver stall pattern and result check
  int stall_mode = 0;
  int cyc = 0;
  int quiet = 0;
  always @(posedge clk) begin
    result_t e;
    cyc++;
    if (cyc % 97 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: result_stall <= 1'b0;
      1: result_stall <= $urandom_range(0, 1);
      2: result_stall <= (cyc % 3 == 0);
      default: result_stall <= ($urandom_range(0, 3) != 0);
    endcase
    if (!rst && result_valid && !result_stall) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word %p", result);
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (result.out_byte !== e.out_byte) begin
          $error("out_byte expected %0h got %0h", e.out_byte, result.out_byte);
          errors++;
        end
        if (result.status !== e.status) begin
          $error("status expected %0d got %0d", e.status, result.status);
          errors++;
        end
        if (result.decoded_length !== e.decoded_length) begin
          $error("decoded_length expected %0d got %0d", e.decoded_length,
                 result.decoded_length);
          errors++;
        end
        if (result.run_last !== e.run_last) begin
          $error("run_last expected %0d got %0d", e.run_last, result.run_last);
          errors++;
        end
      end
    end
    // Watchdog on handshake progress
    if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready) || rst)
      quiet = 0;
    else
      quiet++;
    if (quiet > STALL_LIMIT) begin
      $display("FAIL snappy_stream_decompressor");
      $finish;
    end
  end

  function automatic void push_bytes(byte unsigned s[$], bit bare_end);
    for (int i = 0; i < s.size(); i++)
      pending_words.push_back('{s[i], 1'b1, (!bare_end && i == s.size() - 1)});
    if (bare_end || s.size() == 0)
      pending_words.push_back('{8'($urandom), 1'b0, 1'b1});
  endfunction

  // Build one stream of the given decoded length, optionally damaged
  function automatic int add_stream(int unsigned len, bit corrupt);
    byte unsigned s[$];
    int unsigned v, p, rem, n, off, r, k;
    v = len;
    do begin
      s.push_back({(v > 127), v[6:0]});
      v >>= 7;
    end while (v != 0);
    p = 0;
    while (p < len) begin
      rem = len - p;
      r = (p == 0) ? 0 : $urandom_range(0, 3);
      if (r == 1 && rem < 4) r = 2;
      if (r == 0) begin
        n = $urandom_range(1, rem > 70 ? 70 : rem);
        if (n <= 60 && $urandom_range(0, 3) != 0) begin
          s.push_back((n - 1) << 2);
        end else begin
          k = $urandom_range(60, 63);
          s.push_back(k << 2);
          for (int i = 0; i < k - 59; i++) s.push_back(((n - 1) >> (8 * i)) & 8'hFF);
        end
        for (int i = 0; i < n; i++) s.push_back($urandom_range(0, 255));
      end else begin
        off = $urandom_range(1, p > 2047 ? 2047 : p);
        if (r == 1) begin
          n = $urandom_range(4, rem < 11 ? rem : 11);
          s.push_back(((off >> 8) << 5) | ((n - 4) << 2) | 1);
          s.push_back(off & 8'hFF);
        end else begin
          n = $urandom_range(1, rem < 64 ? rem : 64);
          s.push_back(((n - 1) << 2) | r[1:0]);
          for (int i = 0; i < (r == 2 ? 2 : 4); i++) s.push_back((off >> (8 * i)) & 8'hFF);
        end
      end
      p += n;
    end
    if (corrupt) begin
      case ($urandom_range(0, 2))
        0: s[$urandom_range(0, s.size() - 1)] = $urandom_range(0, 255);
        1: repeat ($urandom_range(1, 3)) if (s.size() > 1) void'(s.pop_back());
        default: s.push_back($urandom_range(0, 255));
      endcase
    end
    push_bytes(s, $urandom_range(0, 4) == 0);
    return s.size();
  endfunction

  task automatic wait_drained();
    while (pending_words.size() != 0 || item_valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_max_len(logic [31:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    max_len = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int words);
    int sent;
    int unsigned len;
    sent = 0;
    while (sent < words) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 40);
      sent += add_stream(len, $urandom_range(0, 4) == 0);
      if ($urandom_range(0, 5) == 0) begin
        pending_words.push_back('{8'($urandom), 1'b0, 1'b0});
      end
      if ($urandom_range(0, 9) == 0) begin
        // noise stream
        repeat ($urandom_range(1, 8)) begin
          pending_words.push_back('{8'($urandom), 1'b1, 1'b0});
          sent++;
        end
        pending_words.push_back('{8'($urandom), 1'b1, 1'b1});
      end
    end
  endtask

  initial begin
    byte unsigned s[$];
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty stream, zero header, bad varint, max header truncated
    push_bytes(s, 1);
    s = '{8'h00}; push_bytes(s, 0);
    s = '{8'h80, 8'h80, 8'h80, 8'h80, 8'h10, 8'h00}; push_bytes(s, 0);
    s = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F}; push_bytes(s, 0);
    // literal overrun, zero offset, trailing byte
    s = '{8'h01, 8'h04, 8'h41}; push_bytes(s, 0);
    s = '{8'h04, 8'h00, 8'h61, 8'h01, 8'h00}; push_bytes(s, 0);
    s = '{8'h01, 8'h00, 8'h78, 8'h79}; push_bytes(s, 0);
    // offset beyond output, 4-byte copy
    s = '{8'h05, 8'h00, 8'h55, 8'h03, 8'h02, 8'h00, 8'h00, 8'h00}; push_bytes(s, 0);
    s = '{8'h04, 8'h00, 8'hAA, 8'h0B, 8'h01, 8'h00, 8'h00, 8'h00}; push_bytes(s, 0);
    // 64-byte copy on end word defers its status, bare word flushes it
    s = '{8'h41, 8'h00, 8'h7A, 8'hFE, 8'h01, 8'h00}; push_bytes(s, 0);
    pending_words.push_back('{8'hFF, 1'b0, 1'b0});
    run_random(30);

    // Pause until all results are in, then tighter limits
    write_max_len(32'd0);
    s = '{8'h00}; push_bytes(s, 0);
    run_random(10);
    write_max_len(32'd100);
    run_random(30);
    write_max_len($urandom_range(20, 60));
    run_random(20);
    write_max_len(32'hFFFF_FFFF);
    s = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F, 8'h00, 8'h00}; push_bytes(s, 0);
    run_random(10);

    while (pending_words.size() != 0 || item_valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0)
      $display("PASS snappy_stream_decompressor");
    else
      $display("FAIL snappy_stream_decompressor");
    $finish;
  end

endmodule

/* snappy_stream_decompressor.f */
design/snpdec_pkg.sv
design/snpdec_ctrl.sv
design/snpdec_dp.sv
design/snappy_stream_decompressor.sv
verif/snappy_stream_decompressor_tb.sv
